FILE: rtl/tsn_pkg.sv
// shared types, constants, hash and blend functions for the star nebula texel pipeline
`timescale 1ns / 1ps
`default_nettype none
package tsn_pkg;

  // texture geometry
  localparam int TEX_SIZE = 512;
  localparam int TEX_LOG2 = $clog2(TEX_SIZE);
  localparam int COORD_W  = 9;
  localparam logic [COORD_W-1:0] TEX_MASK = COORD_W'(TEX_SIZE - 1);

  // pipeline depth
  localparam int NSTG     = 13;
  localparam int OCT_STG  = 5;
  localparam int STAR_STG = 12;
  localparam int SHD_STG  = NSTG - OCT_STG;

  // octave lattices
  localparam int OCT_A_CELLS = 6;
  localparam int OCT_A_SEED  = 11;
  localparam int OCT_B_CELLS = 13;
  localparam int OCT_B_SEED  = 29;
  localparam int STAR_SEED   = 101;

  // hash multipliers
  localparam logic [31:0] HASH_KX   = 32'd374761393;
  localparam logic [31:0] HASH_KY   = 32'd668265263;
  localparam logic [31:0] HASH_KS   = 32'd2654435761;
  localparam logic [31:0] HASH_KMIX = 32'd1274126177;

  // constants with 24 fraction bits: q0.24, but ONE_Q24 is q1.24 and SPAN_RCP q2.24
  localparam logic [24:0] ONE_Q24  = 25'd16777216;
  localparam logic [23:0] W_OCT_A  = 24'd10066330;
  localparam logic [23:0] W_OCT_B  = 24'd6710886;
  localparam logic [23:0] NEB_CUT  = 24'd9227469;
  localparam logic [22:0] NEB_SPAN = 23'd7549747;
  localparam logic [25:0] SPAN_RCP = 26'd37282703;
  localparam logic [23:0] R_BASE   = 24'd33554;
  localparam logic [23:0] R_GAIN   = 24'd1677722;
  localparam logic [23:0] G_BASE   = 24'd50332;
  localparam logic [23:0] G_GAIN   = 24'd838861;
  localparam logic [23:0] B_BASE   = 24'd100663;
  localparam logic [23:0] B_GAIN   = 24'd4697620;
  localparam logic [23:0] STAR_HI  = 24'd16643019;
  localparam logic [23:0] STAR_LO  = 24'd16408117;
  localparam logic [23:0] DIM_RG   = 24'd5033165;
  localparam logic [23:0] DIM_B    = 24'd5536481;

  typedef struct packed {
    logic [8:0] pixel_x;
    logic [8:0] pixel_y;
  } texel_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } texel_out_t;

  typedef struct packed {
    logic bright;
    logic dim;
  } star_t;

  // lattice hash, first step: linear combination of the corner indices
  function automatic logic [31:0] hash_pre(input logic [COORD_W-1:0] a,
                                           input logic [COORD_W-1:0] b,
                                           input logic [31:0] seed);
    hash_pre = 32'(32'(a) * HASH_KX) + 32'(32'(b) * HASH_KY) + 32'(seed * HASH_KS);
  endfunction

  // lattice hash, second step: xor shift and multiply
  function automatic logic [31:0] hash_mix(input logic [31:0] h);
    hash_mix = 32'((h ^ (h >> 13)) * HASH_KMIX);
  endfunction

  // lattice hash, last step: fold and keep 24 bits
  function automatic logic [23:0] hash_fin(input logic [31:0] h);
    logic [31:0] f;
    f = h ^ (h >> 16);
    hash_fin = f[23:0];
  endfunction

  // linear blend in q0.24
  function automatic logic [23:0] blend(input logic [23:0] a, input logic [23:0] b,
                                        input logic [24:0] s);
    logic [49:0] p;
    p = 50'(a) * 50'(ONE_Q24 - s) + 50'(b) * 50'(s);
    blend = p[47:24];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tsn_octave.sv
// one octave of tiling value noise: lattice, smoothstep, hash and bilinear blend
`timescale 1ns / 1ps
`default_nettype none
module tsn_octave import tsn_pkg::*; #(
  parameter int CELLS = OCT_A_CELLS,
  parameter int SEED  = OCT_A_SEED
) (
  input  wire logic               clk,
  input  wire logic [OCT_STG-1:0] en,
  input  wire logic [COORD_W-1:0] px,
  input  wire logic [COORD_W-1:0] py,
  output logic [23:0]             noise_r
);

  localparam int IW = $clog2(CELLS);
  localparam int DW = TEX_LOG2 + 1;
  localparam int NW = DW + IW;

  logic [NW-1:0] nx, ny;
  logic [IW-1:0] ix0_nxt, ix1_nxt, iy0_nxt, iy1_nxt;
  logic [IW-1:0] ix0_r, ix1_r, iy0_r, iy1_r;
  logic [23:0]   tx_r, ty_r, tx1_r, ty1_r, tx2_r, ty2_r;
  logic [31:0]   h0_r [4];
  logic [31:0]   h1_r [4];
  logic [24:0]   sx_r, sy_r, sy3_r;
  logic [47:0]   sqx, sqy;
  logic [49:0]   smx, smy;
  logic [23:0]   top_r, bot_r;

  // texel center on the lattice
  always_comb begin
    nx = NW'((2 * 32'(px) + 1) * CELLS);
    ny = NW'((2 * 32'(py) + 1) * CELLS);
    ix0_nxt = nx[NW-1:DW];
    iy0_nxt = ny[NW-1:DW];
    ix1_nxt = (ix0_nxt == IW'(CELLS - 1)) ? '0 : ix0_nxt + 1'b1;
    iy1_nxt = (iy0_nxt == IW'(CELLS - 1)) ? '0 : iy0_nxt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ix0_r <= ix0_nxt;
      ix1_r <= ix1_nxt;
      iy0_r <= iy0_nxt;
      iy1_r <= iy1_nxt;
      tx_r  <= {nx[DW-1:0], (24-DW)'(0)};
      ty_r  <= {ny[DW-1:0], (24-DW)'(0)};
    end
  end

  // square the fractions, start the corner hashes
  assign sqx = 48'(tx_r) * 48'(tx_r);
  assign sqy = 48'(ty_r) * 48'(ty_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      tx2_r   <= sqx[47:24];
      ty2_r   <= sqy[47:24];
      tx1_r   <= tx_r;
      ty1_r   <= ty_r;
      h0_r[0] <= hash_pre(COORD_W'(ix0_r), COORD_W'(iy0_r), 32'(SEED));
      h0_r[1] <= hash_pre(COORD_W'(ix1_r), COORD_W'(iy0_r), 32'(SEED));
      h0_r[2] <= hash_pre(COORD_W'(ix0_r), COORD_W'(iy1_r), 32'(SEED));
      h0_r[3] <= hash_pre(COORD_W'(ix1_r), COORD_W'(iy1_r), 32'(SEED));
    end
  end

  // smoothstep weights, mix the hashes
  assign smx = 50'(tx2_r) * 50'(26'(3 * 2**24) - {2'b0, tx1_r} - {2'b0, tx1_r});
  assign smy = 50'(ty2_r) * 50'(26'(3 * 2**24) - {2'b0, ty1_r} - {2'b0, ty1_r});

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sx_r <= smx[48:24];
      sy_r <= smy[48:24];
      for (int i = 0; i < 4; i++) begin
        h1_r[i] <= hash_mix(h0_r[i]);
      end
    end
  end

  // blend along x
  always_ff @(posedge clk) begin
    if (en[3]) begin
      top_r <= blend(hash_fin(h1_r[0]), hash_fin(h1_r[1]), sx_r);
      bot_r <= blend(hash_fin(h1_r[2]), hash_fin(h1_r[3]), sx_r);
      sy3_r <= sy_r;
    end
  end

  // blend along y
  always_ff @(posedge clk) begin
    if (en[4]) begin
      noise_r <= blend(top_r, bot_r, sy3_r);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tsn_star.sv
// per-texel star hash, threshold compare and delay to the color stage
`timescale 1ns / 1ps
`default_nettype none
module tsn_star import tsn_pkg::*; (
  input  wire logic                clk,
  input  wire logic [STAR_STG-1:0] en,
  input  wire logic [COORD_W-1:0]  px,
  input  wire logic [COORD_W-1:0]  py,
  output star_t                    star
);

  logic [31:0] h0_r, h1_r;
  logic [23:0] hs;
  star_t       star_r [2:STAR_STG-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      h0_r <= hash_pre(px & TEX_MASK, py & TEX_MASK, 32'(STAR_SEED));
    end
    if (en[1]) begin
      h1_r <= hash_mix(h0_r);
    end
  end

  // classify the texel
  assign hs = hash_fin(h1_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      star_r[2].bright <= hs > STAR_HI;
      star_r[2].dim    <= hs > STAR_LO;
    end
    for (int k = 3; k < STAR_STG; k++) begin
      if (en[k]) begin
        star_r[k] <= star_r[k-1];
      end
    end
  end

  assign star = star_r[STAR_STG-1];

endmodule
`default_nettype wire

FILE: rtl/tsn_shade.sv
// nebula mix, threshold divide, cube, tint and star overlay down to bytes
`timescale 1ns / 1ps
`default_nettype none
module tsn_shade import tsn_pkg::*; (
  input  wire logic               clk,
  input  wire logic [SHD_STG-1:0] en,
  input  wire logic [23:0]        noise_a,
  input  wire logic [23:0]        noise_b,
  input  wire star_t              star,
  output texel_out_t              texel_r
);

  logic [48:0] nsum;
  logic [23:0] neb_r;
  logic [22:0] d_nxt, d6_r, d7_r;
  logic [48:0] qp;
  logic [24:0] q06_r, q07_r;
  logic [47:0] prod7_r;
  logic [46:0] rem;
  logic [24:0] q_nxt, q8_r, q9_r, q2_r, q3_r;
  logic [49:0] sq, cu;
  logic [48:0] pr, pg, pb;
  logic [24:0] r_r, g_r, b_r;
  logic [25:0] rs, gs, bs;
  texel_out_t  texel_nxt;

  // octave mix
  assign nsum = 49'(48'(W_OCT_A) * 48'(noise_a)) + 49'(48'(W_OCT_B) * 48'(noise_b));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neb_r <= nsum[47:24];
    end
  end

  // threshold and reciprocal estimate of the rescale
  always_comb begin
    d_nxt = (neb_r > NEB_CUT) ? 23'(neb_r - NEB_CUT) : '0;
    qp    = 49'(d_nxt) * 49'(SPAN_RCP);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d6_r  <= d_nxt;
      q06_r <= qp[48:24];
    end
    if (en[2]) begin
      d7_r    <= d6_r;
      q07_r   <= q06_r;
      prod7_r <= 48'(q06_r) * 48'(NEB_SPAN);
    end
  end

  // one correction step and clamp
  always_comb begin
    rem   = {d7_r, 24'b0} - prod7_r[46:0];
    q_nxt = q07_r + 25'(rem >= 47'(NEB_SPAN));
    if (q_nxt > ONE_Q24) begin
      q_nxt = ONE_Q24;
    end
  end

  // cube
  assign sq = 50'(q8_r) * 50'(q8_r);
  assign cu = 50'(q2_r) * 50'(q9_r);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      q8_r <= q_nxt;
    end
    if (en[4]) begin
      q2_r <= sq[48:24];
      q9_r <= q8_r;
    end
    if (en[5]) begin
      q3_r <= cu[48:24];
    end
  end

  // blue tint
  assign pr = 49'(R_GAIN) * 49'(q3_r);
  assign pg = 49'(G_GAIN) * 49'(q3_r);
  assign pb = 49'(B_GAIN) * 49'(q3_r);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      r_r <= 25'(R_BASE) + 25'(pr[48:24]);
      g_r <= 25'(G_BASE) + 25'(pg[48:24]);
      b_r <= 25'(B_BASE) + 25'(pb[48:24]);
    end
  end

  // clamp and round one channel
  function automatic logic [7:0] to_byte(input logic [25:0] c);
    logic [25:0] cc;
    logic [33:0] t;
    cc = (c > 26'(ONE_Q24)) ? 26'(ONE_Q24) : c;
    t  = ({cc, 8'b0} - 34'(cc)) + 34'(2**23);
    to_byte = t[31:24];
  endfunction

  // star overlay
  always_comb begin
    rs = 26'(r_r);
    gs = 26'(g_r);
    bs = 26'(b_r);
    if (star.bright) begin
      rs = 26'(ONE_Q24);
      gs = 26'(ONE_Q24);
      bs = 26'(ONE_Q24);
    end else if (star.dim) begin
      rs = rs + 26'(DIM_RG);
      gs = gs + 26'(DIM_RG);
      bs = bs + 26'(DIM_B);
    end
    texel_nxt.red   = to_byte(rs);
    texel_nxt.green = to_byte(gs);
    texel_nxt.blue  = to_byte(bs);
    texel_nxt.alpha = 8'hFF;
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      texel_r <= texel_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tileable_star_nebula_texel.sv
// throughput: one word per cycle unless the output stalls; thirteen register stages, each with its own valid bit
// a stage loads when it is empty or the stage after it moves, so bubbles close up
// under a stall and the output register keeps its word until it is taken
// reset clears all valid bits; the data registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module tileable_star_nebula_texel import tsn_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire texel_in_t  in_word,
  output logic            out_valid,
  input  wire logic       out_stall,
  output texel_out_t      out_word
);

  logic [NSTG-1:0] v_r, v_nxt, en;
  logic [23:0]     noise_a, noise_b;
  star_t           star;

  // stage enables, from the output back
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  // valid bits travel with the data
  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  tsn_octave #(.CELLS(OCT_A_CELLS), .SEED(OCT_A_SEED)) u_oct_a (
    .clk     (clk),
    .en      (en[OCT_STG-1:0]),
    .px      (in_word.pixel_x),
    .py      (in_word.pixel_y),
    .noise_r (noise_a)
  );

  tsn_octave #(.CELLS(OCT_B_CELLS), .SEED(OCT_B_SEED)) u_oct_b (
    .clk     (clk),
    .en      (en[OCT_STG-1:0]),
    .px      (in_word.pixel_x),
    .py      (in_word.pixel_y),
    .noise_r (noise_b)
  );

  tsn_star u_star (
    .clk  (clk),
    .en   (en[STAR_STG-1:0]),
    .px   (in_word.pixel_x),
    .py   (in_word.pixel_y),
    .star (star)
  );

  tsn_shade u_shade (
    .clk     (clk),
    .en      (en[NSTG-1:OCT_STG]),
    .noise_a (noise_a),
    .noise_b (noise_b),
    .star    (star),
    .texel_r (out_word)
  );

  assign out_valid = v_r[NSTG-1];

  // the input is held off only when every stage is full
  assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> (&v_r))
    else $error("input stalled with an empty stage");

  // an accepted word lands in the first stage
  assert property (@(posedge clk) disable iff (!rst_n) (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted word lost at entry");

  // a stalled output word stays valid
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled output word dropped or changed");

  // a word in the last inner stage moves on when the output frees up
  assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTG-2] && !out_valid) |=> out_valid)
    else $error("word stuck ahead of an empty output");

endmodule
`default_nettype wire
